FILE: hdl/srpg_pkg.sv
// Shared types, constants and SHA-256 tables of the pool random generator.
package srpg_pkg;

   localparam int HALF_BYTES = 16;
   localparam int LEN_W = 61;

   typedef struct packed {
      logic        mode;
      logic [7:0]  seed_byte;
      logic        seed_last;
      logic [63:0] timestamp;
      logic [4:0]  byte_count;
   } item_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_stat_type;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_POOL = 9'b000000010,
      ST_SEED = 9'b000000100,
      ST_CTR  = 9'b000001000,
      ST_TS   = 9'b000010000,
      ST_PAD  = 9'b000100000,
      ST_LEN  = 9'b001000000,
      ST_FIN  = 9'b010000000,
      ST_OUT  = 9'b100000000
   } state_type;

   localparam logic MODE_SEED = 1'b0;
   localparam logic MODE_GEN = 1'b1;

   localparam logic [255:0] HASH_IV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

FILE: hdl/srpg_front.sv
// Front end: accepts items, drops empty generate requests, saturates counts and queues items.
module srpg_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [7:0]         req_seed_byte,
   input  logic               req_seed_last,
   input  logic [63:0]        req_timestamp,
   input  logic [4:0]         req_byte_count,
   output logic               q_valid,
   output srpg_pkg::item_type q_item,
   input  logic               q_pop
);

   srpg_pkg::item_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       drop;
   srpg_pkg::item_type item;

   assign req_ready = (cnt_ff != 2'd2);
   assign drop = (req_mode == srpg_pkg::MODE_GEN) && (req_byte_count == 5'd0);
   assign push = req_valid && req_ready && !drop;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = mem_ff[rd_ptr_ff];

   always_comb begin
      item.mode = req_mode;
      item.seed_byte = req_seed_byte;
      item.seed_last = req_seed_last;
      item.timestamp = req_timestamp;
      item.byte_count = (req_byte_count > 5'(srpg_pkg::HALF_BYTES)) ?
                        5'(srpg_pkg::HALF_BYTES) : req_byte_count;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

FILE: hdl/srpg_core.sv
// Iterative SHA-256 compression unit, one round per cycle.
module srpg_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [511:0]            block,
   input  logic [255:0]            hash,
   output srpg_pkg::core_stat_type stat,
   output logic [255:0]            hash_out
);

   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [5:0]  rnd_ff, rnd_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] t1, t2, s0, s1, wn;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   always_comb begin
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wn = w_ff[0] + s0 + w_ff[9] + s1;
      t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25)) +
           ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + srpg_pkg::ROUND_K[rnd_ff] + w_ff[0];
      t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22)) +
           ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      v_in = v_ff;
      w_in = w_ff;
      rnd_in = rnd_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         for (int i = 0; i < 8; i++) begin
            v_in[i] = hash[255 - 32 * i -: 32];
         end
         for (int i = 0; i < 16; i++) begin
            w_in[i] = block[511 - 32 * i -: 32];
         end
         rnd_in = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[15] = wn;
         rnd_in = rnd_ff + 6'd1;
         if (rnd_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      for (int i = 0; i < 8; i++) begin
         hash_out[255 - 32 * i -: 32] = hash[255 - 32 * i -: 32] + v_ff[i];
      end
      stat.busy = busy_ff;
      stat.done = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         rnd_ff <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      w_ff <= w_in;
   end

endmodule

FILE: hdl/srpg_engine.sv
// Back end: builds each SHA-256 message byte by byte, keeps the pool and emits random bytes.
module srpg_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  srpg_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_random_byte,
   output logic               rsp_last_byte
);

   srpg_pkg::state_type     state_ff, state_in;
   srpg_pkg::item_type      cur_ff, cur_in;
   srpg_pkg::core_stat_type stat;
   logic [255:0]            pool_ff, pool_in;
   logic [255:0]            hash_ff, hash_in;
   logic [255:0]            hash_out;
   logic [127:0]            dig_ff, dig_in;
   logic [511:0]            block_ff, block_in;
   logic [srpg_pkg::LEN_W-1:0] len_ff, len_in;
   logic [63:0]             bits_ff, bits_in;
   logic [31:0]             gen_ff, gen_in;
   logic [4:0]              idx_ff, idx_in;
   logic                    act_ff, act_in;
   logic                    pend_ff, pend_in;
   logic                    hold;
   logic                    absorb;
   logic [7:0]              abs_byte;
   logic [7:0]              pool_sel;
   logic [5:0]              len_sel;
   logic [6:0]              out_sel;

   srpg_core u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (pend_ff),
      .block    (block_ff),
      .hash     (hash_ff),
      .stat     (stat),
      .hash_out (hash_out)
   );

   assign hold = pend_ff || stat.busy || stat.done;
   assign pool_sel = {5'(5'd31 - idx_ff), 3'b000};
   assign len_sel = {3'(3'd7 - idx_ff[2:0]), 3'b000};
   assign out_sel = {4'(4'd15 - idx_ff[3:0]), 3'b000};
   assign rsp_valid = (state_ff == srpg_pkg::ST_OUT);
   assign rsp_random_byte = dig_ff[out_sel +: 8];
   assign rsp_last_byte = (idx_ff == 5'(cur_ff.byte_count - 5'd1));

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      pool_in = pool_ff;
      hash_in = stat.done ? hash_out : hash_ff;
      dig_in = dig_ff;
      bits_in = bits_ff;
      gen_in = gen_ff;
      idx_in = idx_ff;
      act_in = act_ff;
      q_pop = 1'b0;
      absorb = 1'b0;
      abs_byte = 8'h00;
      case (state_ff)
         srpg_pkg::ST_IDLE: begin
            if (q_valid && !hold) begin
               q_pop = 1'b1;
               cur_in = q_item;
               idx_in = 5'd0;
               if (q_item.mode == srpg_pkg::MODE_GEN || !act_ff) begin
                  hash_in = srpg_pkg::HASH_IV;
                  state_in = srpg_pkg::ST_POOL;
               end else begin
                  state_in = srpg_pkg::ST_SEED;
               end
               if (q_item.mode == srpg_pkg::MODE_GEN) begin
                  act_in = 1'b0;
                  gen_in = gen_ff + 32'd1;
               end else begin
                  act_in = 1'b1;
               end
            end
         end
         srpg_pkg::ST_POOL: begin
            abs_byte = pool_ff[pool_sel +: 8];
            if (!hold) begin
               absorb = 1'b1;
               idx_in = idx_ff + 5'd1;
               if (idx_ff == 5'd31) begin
                  idx_in = 5'd0;
                  state_in = (cur_ff.mode == srpg_pkg::MODE_GEN) ?
                             srpg_pkg::ST_CTR : srpg_pkg::ST_SEED;
               end
            end
         end
         srpg_pkg::ST_SEED: begin
            abs_byte = cur_ff.seed_byte;
            if (!hold) begin
               absorb = 1'b1;
               state_in = cur_ff.seed_last ? srpg_pkg::ST_PAD : srpg_pkg::ST_IDLE;
            end
         end
         srpg_pkg::ST_CTR: begin
            abs_byte = gen_ff[{idx_ff[1:0], 3'b000} +: 8];
            if (!hold) begin
               absorb = 1'b1;
               idx_in = idx_ff + 5'd1;
               if (idx_ff == 5'd3) begin
                  idx_in = 5'd0;
                  state_in = srpg_pkg::ST_TS;
               end
            end
         end
         srpg_pkg::ST_TS: begin
            abs_byte = cur_ff.timestamp[{idx_ff[2:0], 3'b000} +: 8];
            if (!hold) begin
               absorb = 1'b1;
               idx_in = idx_ff + 5'd1;
               if (idx_ff == 5'd7) begin
                  idx_in = 5'd0;
                  state_in = srpg_pkg::ST_PAD;
               end
            end
         end
         srpg_pkg::ST_PAD: begin
            abs_byte = (idx_ff == 5'd0) ? 8'h80 : 8'h00;
            if (!hold) begin
               absorb = 1'b1;
               idx_in = 5'd1;
               if (idx_ff == 5'd0) begin
                  bits_in = {len_ff, 3'b000};
               end
               if (len_in[5:0] == 6'd56) begin
                  idx_in = 5'd0;
                  state_in = srpg_pkg::ST_LEN;
               end
            end
         end
         srpg_pkg::ST_LEN: begin
            abs_byte = bits_ff[len_sel +: 8];
            if (!hold) begin
               absorb = 1'b1;
               idx_in = idx_ff + 5'd1;
               if (idx_ff == 5'd7) begin
                  idx_in = 5'd0;
                  state_in = srpg_pkg::ST_FIN;
               end
            end
         end
         srpg_pkg::ST_FIN: begin
            if (!hold) begin
               act_in = 1'b0;
               if (cur_ff.mode == srpg_pkg::MODE_SEED) begin
                  pool_in = hash_ff;
                  state_in = srpg_pkg::ST_IDLE;
               end else begin
                  pool_in[255:128] = hash_ff[255:128];
                  dig_in = hash_ff[127:0];
                  idx_in = 5'd0;
                  state_in = srpg_pkg::ST_OUT;
               end
            end
         end
         srpg_pkg::ST_OUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 5'd1;
               if (rsp_last_byte) begin
                  idx_in = 5'd0;
                  state_in = srpg_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = srpg_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      block_in = block_ff;
      len_in = len_ff;
      pend_in = 1'b0;
      if (state_ff == srpg_pkg::ST_IDLE && q_pop && hash_in == srpg_pkg::HASH_IV &&
          (q_item.mode == srpg_pkg::MODE_GEN || !act_ff)) begin
         len_in = '0;
      end
      if (absorb) begin
         block_in = {block_ff[503:0], abs_byte};
         len_in = len_ff + srpg_pkg::LEN_W'(1);
         pend_in = (len_ff[5:0] == 6'd63);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srpg_pkg::ST_IDLE;
         pool_ff <= '0;
         hash_ff <= srpg_pkg::HASH_IV;
         len_ff <= '0;
         gen_ff <= 32'd0;
         idx_ff <= 5'd0;
         act_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pool_ff <= pool_in;
         hash_ff <= hash_in;
         len_ff <= len_in;
         gen_ff <= gen_in;
         idx_ff <= idx_in;
         act_ff <= act_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      dig_ff <= dig_in;
      bits_ff <= bits_in;
      block_ff <= block_in;
   end

endmodule

FILE: hdl/sha256_pool_random_generator_top.sv
// Top level of the SHA-256 pool random generator.
// A generate item is dequeued, its 64 message bytes absorbed, the core started and run, the
// hash folded in and the digest loaded by a finish step; its bytes then follow at one per
// cycle while rsp_ready is high. A seed item is dequeued and its byte absorbed, after the 32
// pool bytes if it opens a message; full blocks are compressed; last items add padding, length.
// Synchronous reset clears the pool, the counter, the queue and all control state.
module sha256_pool_random_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_seed_byte,
   input  logic        req_seed_last,
   input  logic [63:0] req_timestamp,
   input  logic [4:0]  req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_random_byte,
   output logic        rsp_last_byte
);

   logic               q_valid;
   logic               q_pop;
   srpg_pkg::item_type q_item;

   srpg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_seed_byte  (req_seed_byte),
      .req_seed_last  (req_seed_last),
      .req_timestamp  (req_timestamp),
      .req_byte_count (req_byte_count),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   srpg_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_random_byte (rsp_random_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

endmodule

FILE: hdl/srpg_checker.sv
// Port-level checker for the pool random generator, bound to the top level.
module srpg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_random_byte,
   input logic        rsp_last_byte
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_random_byte) &&
      $stable(rsp_last_byte))
      else $error("A stalled result item changed.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("A result item was offered right after reset.");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("The input was not ready right after reset.");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_byte |=> rsp_valid)
      else $error("A byte run stopped before its last item.");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_byte |=> !rsp_valid)
      else $error("A result item followed the last byte without a new request.");

endmodule

bind sha256_pool_random_generator_top srpg_checker u_srpg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_random_byte (rsp_random_byte),
   .rsp_last_byte   (rsp_last_byte)
);
